FILE: src/sld_pkg.sv
// Shared constants, types and offset tables of the stride LZ decompressor.
package sld_pkg;

  localparam int MaxStride      = 1024;
  localparam int WindowDepth    = 4096;
  localparam int OutputCapacity = 262144;

  localparam int ByteW   = 8;
  localparam int StrideW = 11;
  localparam int LimitW  = 19;
  localparam int CountW  = 19;
  localparam int StatusW = 3;
  localparam int LenW    = 5;
  localparam int ModeW   = 3;
  localparam int CfgW    = 19;
  localparam int CfgIdxW = 1;
  localparam int AddrW   = $clog2(WindowDepth);
  // Signed copy distance, enough for three plus one row.
  localparam int DistW   = $clog2(2 * MaxStride + 4) + 1;

  typedef enum logic [StatusW-1:0] {
    STAT_RUNNING = 3'd0,
    STAT_END     = 3'd1,
    STAT_SRC_END = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_BAD_REF = 3'd4
  } sld_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_STRIDE   = 1'b0,
    REG_OUTPUT_LIMIT = 1'b1
  } sld_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_STATUS,
    ST_DONE
  } sld_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        latch;
    logic        lit_emit;
    logic        set_pending;
    logic        load_copy;
    logic        rd_issue;
    logic        copy_emit;
    logic        status_emit;
    logic        code_we;
    sld_status_e code;
  } sld_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic pending_nz;
    logic mode_zero;
    logic len_zero;
    logic full;
    logic bad_ref;
    logic count_one;
    logic out_free;
  } sld_sts_t;

  // Negated base offset of each copy mode.
  function automatic logic signed [2:0] neg_base(input logic [ModeW-1:0] mode);
    logic signed [2:0] nb;
    unique case (mode)
      3'd1:    nb = 3'sd1;
      3'd3:    nb = 3'sd1;
      3'd4:    nb = 3'sd2;
      3'd5:    nb = 3'sd3;
      3'd6:    nb = -3'sd1;
      3'd7:    nb = -3'sd2;
      default: nb = 3'sd0;
    endcase
    return nb;
  endfunction

  // Modes two and up reach one row (two bytes per pixel) back.
  function automatic logic up_ref(input logic [ModeW-1:0] mode);
    return (mode >= 3'd2);
  endfunction

endpackage

FILE: src/sld_src_if.sv
// Compressed source byte channel.
interface sld_src_if
  import sld_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] src_byte;
  logic             src_last;

  modport source (output valid, output src_byte, output src_last, input ready);
  modport sink   (input valid, input src_byte, input src_last, output ready);
endinterface

FILE: src/sld_res_if.sv
// Decoded result channel.
interface sld_res_if
  import sld_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   out_byte;
  logic               byte_valid;
  logic               run_last;
  logic               finished;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  bytes_written;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output finished, output status, output bytes_written, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input finished, input status, input bytes_written, output ready);
endinterface

FILE: src/sld_cfg_if.sv
// Configuration register write channel.
interface sld_cfg_if
  import sld_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] reg_index;
  logic [CfgW-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: src/stride_lz_decompressor.sv
// Sequencing: a request is accepted in the idle state and decoded in the decode state,
// where a literal is written to the result register. A copy then alternates a history
// read state and a write-and-output state for each byte. A literal or a control byte
// that produces no copy passes only the accept and decode steps. A final status takes a
// further status step, and a stalled result consumer holds the sequencer. Reset clears
// all control state; the history window is undefined until written, so it is never cleared.
module stride_lz_decompressor
  import sld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sld_src_if.sink   src_i,
  sld_res_if.source res_o,
  sld_cfg_if.sink   cfg_i
);

  // The controller and the datapath talk only through these two structs.
  sld_cmd_t cmd;
  sld_sts_t sts;

  // The controller owns the source handshake; each accepted request is latched into
  // the datapath and decoded one step at a time.
  sld_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (src_i.valid),
    .src_ready_o (src_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds configuration, write position, literal and copy counters, the
  // history window and the result register that decouples the output side.
  sld_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .src_byte_i (src_i.src_byte),
    .src_last_i (src_i.src_last),
    .cfg_i      (cfg_i),
    .res_o      (res_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

FILE: src/sld_datapath.sv
// Datapath: configuration, counters, history memory and the result register.
module sld_datapath
  import sld_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] src_byte_i,
  input  logic             src_last_i,
  sld_cfg_if.sink          cfg_i,
  sld_res_if.source        res_o,
  input  sld_cmd_t         cmd_i,
  output sld_sts_t         sts_o
);

  logic [StrideW-1:0]      stride_q;
  logic [LimitW-1:0]       limit_q;
  logic [CountW-1:0]       wp_q, wp_d;
  logic [LenW-1:0]         pending_q, pending_d;
  logic [LenW-1:0]         count_q, count_d;
  logic signed [DistW-1:0] dist_q, dist_d;
  logic [ByteW-1:0]        byte_q;
  logic                    last_q;
  sld_status_e             code_q;
  logic [ByteW-1:0]        mem_q [WindowDepth];
  logic [ByteW-1:0]        rdata_q;
  logic [AddrW-1:0]        rd_addr;
  logic                    mem_we;
  logic [ByteW-1:0]        mem_wdata;
  logic                    out_free, out_load;
  logic                    out_valid_q;
  logic [ByteW-1:0]        out_byte_q, out_byte_d;
  logic                    byte_valid_q, byte_valid_d;
  logic                    run_last_q, run_last_d;
  logic                    finished_q, finished_d;
  logic [StatusW-1:0]      status_q, status_d;
  logic [CountW-1:0]       written_q, written_d;
  logic [LenW-1:0]         len;
  logic [ModeW-1:0]        mode;
  logic signed [2:0]       nb;

  assign len  = byte_q[ByteW-1 -: LenW];
  assign mode = byte_q[ModeW-1:0];
  assign nb   = neg_base(mode);

  // Configuration: values beyond the supported range saturate; the row stride is taken from the low StrideW bits first.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= StrideW'(1);
      limit_q  <= LimitW'(OutputCapacity);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_ROW_STRIDE: begin
          stride_q <= (cfg_i.wdata[StrideW-1:0] > StrideW'(MaxStride)) ?
                      StrideW'(MaxStride) : cfg_i.wdata[StrideW-1:0];
        end
        REG_OUTPUT_LIMIT: begin
          limit_q <= (cfg_i.wdata[LimitW-1:0] > LimitW'(OutputCapacity)) ?
                     LimitW'(OutputCapacity) : cfg_i.wdata[LimitW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= src_byte_i;
      last_q <= src_last_i;
    end
    if (cmd_i.code_we) begin
      code_q <= cmd_i.code;
    end
    count_q <= count_d;
    dist_q  <= dist_d;
  end

  always_comb begin
    wp_d      = wp_q;
    pending_d = pending_q;
    count_d   = count_q;
    dist_d    = dist_q;
    if (cmd_i.lit_emit || cmd_i.copy_emit) begin
      wp_d = wp_q + CountW'(1);
    end
    if (cmd_i.lit_emit) begin
      pending_d = pending_q - LenW'(1);
    end
    if (cmd_i.set_pending) begin
      pending_d = len;
    end
    if (cmd_i.load_copy) begin
      count_d = len;
      dist_d  = DistW'(nb) + (up_ref(mode) ? DistW'({stride_q, 1'b0}) : DistW'(0));
    end
    if (cmd_i.copy_emit) begin
      count_d = count_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      pending_q <= '0;
    end else begin
      wp_q      <= wp_d;
      pending_q <= pending_d;
    end
  end

  // History window: one write and one registered read per cycle.
  assign rd_addr   = AddrW'(wp_q) - AddrW'(dist_q);
  assign mem_we    = cmd_i.lit_emit || cmd_i.copy_emit;
  assign mem_wdata = cmd_i.lit_emit ? byte_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q[AddrW-1:0]] <= mem_wdata;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Result register.
  assign out_free = !out_valid_q || res_o.ready;
  assign out_load = cmd_i.lit_emit || cmd_i.copy_emit || cmd_i.status_emit;

  always_comb begin
    out_byte_d   = cmd_i.lit_emit ? byte_q : rdata_q;
    byte_valid_d = 1'b1;
    run_last_d   = !last_q;
    finished_d   = 1'b0;
    status_d     = STAT_RUNNING;
    written_d    = wp_q + CountW'(1);
    if (cmd_i.copy_emit) begin
      run_last_d = (count_q == LenW'(1)) && !last_q;
    end
    if (cmd_i.status_emit) begin
      out_byte_d   = '0;
      byte_valid_d = 1'b0;
      run_last_d   = 1'b1;
      finished_d   = 1'b1;
      status_d     = code_q;
      written_d    = wp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      run_last_q   <= run_last_d;
      finished_q   <= finished_d;
      status_q     <= status_d;
      written_q    <= written_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.out_byte      = out_byte_q;
  assign res_o.byte_valid    = byte_valid_q;
  assign res_o.run_last      = run_last_q;
  assign res_o.finished      = finished_q;
  assign res_o.status        = status_q;
  assign res_o.bytes_written = written_q;

  // Status toward the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.last       = last_q;
    sts_o.pending_nz = (pending_q != '0);
    sts_o.mode_zero  = (mode == '0);
    sts_o.len_zero   = (len == '0);
    sts_o.full       = int'(wp_q) >= int'(limit_q);
    sts_o.bad_ref    = dist_q[DistW-1] || (dist_q == '0) ||
                       (int'(dist_q) > WindowDepth) || (int'(wp_q) < int'(dist_q));
    sts_o.count_one  = (count_q == LenW'(1));
    sts_o.out_free   = out_free;
  end

endmodule

FILE: src/sld_controller.sv
// Controller state machine sequencing decode, copy and status steps.
module sld_controller
  import sld_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     src_valid_i,
  output logic     src_ready_o,
  input  sld_sts_t sts_i,
  output sld_cmd_t cmd_o
);

  sld_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.code  = STAT_SRC_END;
    src_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        src_ready_o = 1'b1;
        if (src_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.pending_nz) begin
          if (sts_i.full) begin
            cmd_o.code_we = 1'b1;
            cmd_o.code    = STAT_FULL;
            state_d       = ST_STATUS;
          end else if (sts_i.out_free) begin
            cmd_o.lit_emit = 1'b1;
            cmd_o.code_we  = sts_i.last;
            state_d        = sts_i.last ? ST_STATUS : ST_IDLE;
          end
        end else if (sts_i.mode_zero) begin
          if (sts_i.len_zero) begin
            cmd_o.code_we = 1'b1;
            cmd_o.code    = STAT_END;
            state_d       = ST_STATUS;
          end else begin
            cmd_o.set_pending = 1'b1;
            cmd_o.code_we     = sts_i.last;
            state_d           = sts_i.last ? ST_STATUS : ST_IDLE;
          end
        end else begin
          cmd_o.load_copy = 1'b1;
          if (sts_i.len_zero) begin
            cmd_o.code_we = sts_i.last;
            state_d       = sts_i.last ? ST_STATUS : ST_IDLE;
          end else begin
            state_d = ST_COPY_RD;
          end
        end
      end
      ST_COPY_RD: begin
        if (sts_i.full) begin
          cmd_o.code_we = 1'b1;
          cmd_o.code    = STAT_FULL;
          state_d       = ST_STATUS;
        end else if (sts_i.bad_ref) begin
          cmd_o.code_we = 1'b1;
          cmd_o.code    = STAT_BAD_REF;
          state_d       = ST_STATUS;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_COPY_WR;
        end
      end
      ST_COPY_WR: begin
        if (sts_i.out_free) begin
          cmd_o.copy_emit = 1'b1;
          if (sts_i.count_one) begin
            cmd_o.code_we = sts_i.last;
            state_d       = sts_i.last ? ST_STATUS : ST_IDLE;
          end else begin
            state_d = ST_COPY_RD;
          end
        end
      end
      ST_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.status_emit = 1'b1;
          state_d           = ST_DONE;
        end
      end
      ST_DONE: begin
        // Requests after the end are taken and dropped.
        src_ready_o = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> state_q == ST_DONE)
    else $error("decoder left the done state without reset");

  a_read_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> state_q == ST_COPY_WR)
    else $error("history read not followed by its copy write step");

  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.status_emit |=> state_q == ST_DONE && !cmd_o.lit_emit && !cmd_o.copy_emit)
    else $error("output produced after the final status");

endmodule

FILE: test/tb_stride_lz_decompressor.sv
// Self-checking testbench for the stride LZ decompressor: directed and random streams.
`timescale 1ns / 100ps

module tb_stride_lz_decompressor
  import sld_pkg::*;
;

  // Clock period is 20 ns.
  localparam int ResetCycles   = 6;
  // Cycles to wait after the last awaited result before touching configuration.
  // A literal-run header or a zero-length copy causes no result but still occupies
  // the decoder for its accept and decode steps.
  localparam int SettleCycles  = 8;
  // Extra cycles at the end to catch any stray result.
  localparam int DrainCycles   = 32;
  // Cycles without any accepted request before the run is declared hung. The longest
  // legal quiet stretch is the forced consumer hold plus a long sender gap.
  localparam int WatchdogLimit = 2500;
  // The one long consumer hold, in cycles.
  localparam int LongHold      = 400;
  // Keep the log short if everything goes wrong.
  localparam int MaxReports    = 40;

  // Copy distance of each mode: base plus twice the row stride times the row step.
  localparam int CopyBase    [8] = '{0, -1,  0, -1, -2, -3,  1,  2};
  localparam int CopyRowStep [8] = '{0,  0, -1, -1, -1, -1, -1, -1};

  typedef enum int {
    PH_CONTROL,
    PH_LITERAL,
    PH_DONE
  } dec_phase_e;

  // Decoding ends only once per reset, so each run picks one way of ending it.
  typedef enum int {
    END_MARKER,
    END_SOURCE,
    END_FULL,
    END_BAD_REF
  } stream_end_e;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               byte_valid;
    logic               run_last;
    logic               finished;
    sld_status_e        status;
    logic [CountW-1:0]  bytes_written;
  } res_t;

  // One row of the directed stream. A nonzero new_stride rewrites the row stride
  // (with the block idle) before the row is sent. Rows with typed set carry their
  // single expected result; all other rows are checked against the decoder model.
  typedef struct packed {
    logic [ByteW-1:0]   src_byte;
    logic               src_last;
    logic [StrideW-1:0] new_stride;
    logic               typed;
    res_t               want;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sld_src_if src_ch ();
  sld_res_if res_ch ();
  sld_cfg_if cfg_ch ();

  stride_lz_decompressor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Behavioral decoder state, kept in step with the requests as they are generated.
  logic [ByteW-1:0] window_copy [WindowDepth];
  int               wr_pos;
  int               lits_left;
  dec_phase_e       dphase;
  int               stride_reg;
  int               limit_reg;

  // Results produced by the request being decoded, then the queue of awaited results.
  res_t             step_batch [$];
  res_t             awaited_results [$];

  int               mismatch_count;
  int               results_seen;
  int               stuck_cycles;
  int               src_calm;
  int               res_calm;

  // Directed stream. Everything runs at the reset stride of 1 until row 19 moves it to
  // 2, which is the smallest stride at which mode 7 points backward. The first literal
  // values and byte counts after reset are obvious, so they are typed in.
  plan_row_t directed_plan [23] = '{
    '{8'h08, 1'b0, 11'd0, 1'b0, '0},                                    // one literal
    '{8'hFF, 1'b0, 11'd0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, STAT_RUNNING, 19'd1}},
    '{8'h10, 1'b0, 11'd0, 1'b0, '0},                                    // two literals
    '{8'h00, 1'b0, 11'd0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, STAT_RUNNING, 19'd2}},
    '{8'h5A, 1'b0, 11'd0, 1'b1, '{8'h5A, 1'b1, 1'b1, 1'b0, STAT_RUNNING, 19'd3}},
    '{8'h19, 1'b0, 11'd0, 1'b0, '0},                                    // left, len 3
    '{8'h01, 1'b0, 11'd0, 1'b0, '0},                                    // empty copy
    '{8'h07, 1'b0, 11'd0, 1'b0, '0},                                    // empty, dist 0
    '{8'h0A, 1'b0, 11'd0, 1'b0, '0},                                    // up
    '{8'h0B, 1'b0, 11'd0, 1'b0, '0},                                    // up-left
    '{8'h0C, 1'b0, 11'd0, 1'b0, '0},
    '{8'h0D, 1'b0, 11'd0, 1'b0, '0},
    '{8'h0E, 1'b0, 11'd0, 1'b0, '0},                                    // up-right
    '{8'hF9, 1'b0, 11'd0, 1'b0, '0},                                    // longest copy
    '{8'h20, 1'b0, 11'd0, 1'b0, '0},                                    // four literals
    '{8'hA5, 1'b0, 11'd0, 1'b0, '0},
    '{8'h3C, 1'b0, 11'd0, 1'b0, '0},
    '{8'hC3, 1'b0, 11'd0, 1'b0, '0},
    '{8'h81, 1'b0, 11'd0, 1'b0, '0},
    '{8'hFF, 1'b0, 11'd2, 1'b0, '0},                                    // mode 7, len 31
    '{8'hFE, 1'b0, 11'd0, 1'b0, '0},
    '{8'h54, 1'b0, 11'd0, 1'b0, '0},
    '{8'h2D, 1'b0, 11'd0, 1'b0, '0}
  };

  // Idle length for either side: mostly none, sometimes a short gap, now and then a
  // long gap, and occasional calm stretches with no idling at all.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Signed distance from the write position to the copy source of a mode.
  function automatic int copy_offset(input int copy_mode);
    int s;
    s = (stride_reg > MaxStride) ? MaxStride : stride_reg;
    return CopyBase[copy_mode] + 2 * CopyRowStep[copy_mode] * s;
  endfunction

  // True if a copy in this mode would start on an already written byte.
  function automatic bit copy_reaches(input int copy_mode);
    int off;
    off = copy_offset(copy_mode);
    return (off < 0) && (wr_pos + off >= 0) && (-off <= WindowDepth);
  endfunction

  function automatic void emit_byte(input logic [ByteW-1:0] v);
    res_t r;
    window_copy[wr_pos % WindowDepth] = v;
    wr_pos++;
    r = '{out_byte: v, byte_valid: 1'b1, run_last: 1'b0, finished: 1'b0,
          status: STAT_RUNNING, bytes_written: CountW'(wr_pos)};
    step_batch.insert(step_batch.size(), r);
  endfunction

  function automatic void close_stream(input sld_status_e code);
    res_t r;
    dphase = PH_DONE;
    r = '{out_byte: '0, byte_valid: 1'b0, run_last: 1'b0, finished: 1'b1,
          status: code, bytes_written: CountW'(wr_pos)};
    step_batch.insert(step_batch.size(), r);
  endfunction

  // Decodes one source byte, updating the model state. The results it causes are
  // appended to the awaited queue when enqueue is set.
  task automatic predict_decode(input logic [ByteW-1:0] b, input logic last,
                                input bit enqueue);
    int   lim;
    int   run_len;
    int   copy_mode;
    int   src_at;
    int   i;
    step_batch.delete();
    lim = (limit_reg > OutputCapacity) ? OutputCapacity : limit_reg;
    if (dphase == PH_DONE) return;
    if (dphase == PH_LITERAL) begin
      if (wr_pos >= lim) begin
        close_stream(STAT_FULL);
      end else begin
        emit_byte(b);
        lits_left--;
        if (lits_left == 0) dphase = PH_CONTROL;
      end
    end else begin
      run_len   = int'(b[7:3]);
      copy_mode = int'(b[2:0]);
      if (copy_mode == 0) begin
        if (run_len == 0) begin
          close_stream(STAT_END);
        end else begin
          lits_left = run_len;
          dphase    = PH_LITERAL;
        end
      end else begin
        // The distance is fixed for the whole copy, so an overlapping copy repeats
        // the bytes it has just written.
        src_at = wr_pos + copy_offset(copy_mode);
        for (i = 0; i < run_len; i++) begin
          if (wr_pos >= lim) begin
            close_stream(STAT_FULL);
            break;
          end
          if (src_at < 0 || src_at >= wr_pos || wr_pos - src_at > WindowDepth) begin
            close_stream(STAT_BAD_REF);
            break;
          end
          emit_byte(window_copy[src_at % WindowDepth]);
          src_at++;
        end
      end
    end
    if (last && dphase != PH_DONE) close_stream(STAT_SRC_END);
    if (step_batch.size() > 0) begin
      step_batch[step_batch.size() - 1].run_last = 1'b1;
    end
    if (enqueue) begin
      foreach (step_batch[k]) awaited_results.insert(awaited_results.size(), step_batch[k]);
    end
  endtask

  // Offers one source request and returns at the edge where it is accepted. Valid is
  // left high, so a following request with no gap goes out back to back.
  task automatic drive_src(input logic [ByteW-1:0] b, input logic last);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      src_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_ch.valid    <= 1'b1;
    src_ch.src_byte <= b;
    src_ch.src_last <= last;
    @(posedge clk_i);
    while (!src_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_item(input logic [ByteW-1:0] b, input logic last);
    predict_decode(b, last, 1'b1);
    drive_src(b, last);
  endtask

  task automatic send_literal_run(input int run_len);
    int k;
    send_item({5'(run_len), 3'd0}, 1'b0);
    for (k = 0; k < run_len; k++) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Stops the source and waits until every awaited result is in and the decoder has
  // had time to finish any request that causes no result.
  task automatic settle();
    src_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input sld_reg_e idx, input logic [CfgW-1:0] v);
    @(posedge clk_i);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_ROW_STRIDE) stride_reg = int'(v[StrideW-1:0]);
    else limit_reg = int'(v);
  endtask

  // Random well-formed stream: literal runs of random content, copies in modes that
  // point at written data, and some empty copies as noise. Bad references, the end
  // marker and the source end all stop decoding for good, so they only come at the end.
  task automatic run_random(input int n_items, input bit long_copies);
    int sent;
    int pick;
    int run_len;
    int copy_mode;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        run_len = (pick < 4) ? $urandom_range(8, 31) : $urandom_range(1, 6);
        send_literal_run(run_len);
        sent += run_len + 1;
      end else if (pick < 27) begin
        send_item({5'd0, 3'($urandom_range(1, 7))}, 1'b0);
        sent++;
      end else begin
        copy_mode = $urandom_range(1, 7);
        if (!copy_reaches(copy_mode)) copy_mode = 1;
        if (long_copies && $urandom_range(0, 1) == 1) run_len = 31;
        else run_len = $urandom_range(1, 31);
        send_item({5'(run_len), 3'(copy_mode)}, 1'b0);
        sent++;
      end
    end
  endtask

  function automatic void check_field(input string what, input logic [CountW-1:0] want,
                                      input logic [CountW-1:0] got);
    if (want !== got) begin
      if (mismatch_count < MaxReports)
        $display("%0t result %s: expected %0h, got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker: every accepted result request is compared with the oldest one
  // awaited.
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = '{out_byte: res_ch.out_byte, byte_valid: res_ch.byte_valid,
              run_last: res_ch.run_last, finished: res_ch.finished,
              status: sld_status_e'(res_ch.status), bytes_written: res_ch.bytes_written};
      results_seen++;
      if (awaited_results.size() == 0) begin
        if (mismatch_count < MaxReports)
          $display("%0t unexpected result: expected none, got byte %0h status %0d count %0d",
                   $time, got.out_byte, got.status, got.bytes_written);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("out_byte", CountW'(want.out_byte), CountW'(got.out_byte));
        check_field("byte_valid", CountW'(want.byte_valid), CountW'(got.byte_valid));
        check_field("run_last", CountW'(want.run_last), CountW'(got.run_last));
        check_field("finished", CountW'(want.finished), CountW'(got.finished));
        check_field("status", CountW'(want.status), CountW'(got.status));
        check_field("bytes_written", want.bytes_written, got.bytes_written);
      end
    end
  end

  // Result consumer. It stalls at random and, once enough results have gone by, holds
  // off for a long stretch while the source keeps offering requests, so the decoder
  // backs up into its input.
  initial begin : result_sink
    int  hold;
    bit  long_hold_done;
    hold           = 0;
    long_hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        hold           = LongHold;
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
        hold = pick_gap(res_calm);
      end
    end
  end

  // Hang detection: too many cycles in which no request moves on any channel.
  always @(posedge clk_i) begin : watchdog
    if ((src_ch.valid === 1'b1 && src_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WatchdogLimit) begin
      $display("tb_stride_lz_decompressor: errors");
      $finish;
    end
  end

  initial begin : stimulus
    stream_end_e how_to_end;
    int          fill;
    int          run_len;
    int          cut;
    int          k;

    src_ch.valid     <= 1'b0;
    src_ch.src_byte  <= '0;
    src_ch.src_last  <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_ROW_STRIDE;
    cfg_ch.wdata     <= '0;

    foreach (window_copy[a]) window_copy[a] = '0;
    wr_pos         = 0;
    lits_left      = 0;
    dphase         = PH_CONTROL;
    stride_reg     = 1;
    limit_reg      = OutputCapacity;
    mismatch_count = 0;
    results_seen   = 0;
    stuck_cycles   = 0;
    src_calm       = 0;
    res_calm       = 0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed stream, starting at the reset configuration.
    foreach (directed_plan[r]) begin
      if (directed_plan[r].new_stride != '0) begin
        settle();
        write_reg(REG_ROW_STRIDE, CfgW'(directed_plan[r].new_stride));
      end
      predict_decode(directed_plan[r].src_byte, directed_plan[r].src_last,
                     !directed_plan[r].typed);
      if (directed_plan[r].typed)
        awaited_results.insert(awaited_results.size(), directed_plan[r].want);
      drive_src(directed_plan[r].src_byte, directed_plan[r].src_last);
    end

    // Largest limit value, which saturates to the capacity, and a modest stride.
    settle();
    write_reg(REG_OUTPUT_LIMIT, '1);
    write_reg(REG_ROW_STRIDE, CfgW'($urandom_range(2, 40)));
    run_random(30, 1'b0);

    // Fill the output exactly up to a limit: reaching it must not end decoding.
    settle();
    fill = $urandom_range(1, 8);
    write_reg(REG_OUTPUT_LIMIT, CfgW'(wr_pos + fill));
    send_literal_run(fill);

    // Widest rows, written either exactly or as a value that saturates. Long copies
    // build up enough history for the upward modes to become reachable.
    settle();
    write_reg(REG_OUTPUT_LIMIT, CfgW'(OutputCapacity));
    write_reg(REG_ROW_STRIDE, ($urandom_range(0, 1) == 1) ? CfgW'(MaxStride) : CfgW'(11'h7FF));
    run_random(40, 1'b1);

    settle();
    write_reg(REG_ROW_STRIDE, CfgW'($urandom_range(3, 200)));
    write_reg(REG_OUTPUT_LIMIT, CfgW'(wr_pos + $urandom_range(5000, 100000)));
    run_random(20, 1'b0);

    // Terminate the stream one way or another.
    settle();
    how_to_end = stream_end_e'($urandom_range(0, 3));
    case (how_to_end)
      END_MARKER: begin
        // With a zero limit the end marker still wins, since it writes nothing.
        write_reg(REG_OUTPUT_LIMIT, '0);
        send_item(8'h00, 1'($urandom_range(0, 1)));
      end
      END_SOURCE: begin
        // The last source byte may fall inside a literal run.
        run_len = $urandom_range(4, 12);
        send_item({5'(run_len), 3'd0}, 1'b0);
        cut = $urandom_range(1, run_len);
        for (k = 1; k <= cut; k++) send_item(8'($urandom_range(0, 255)), k == cut);
      end
      END_FULL: begin
        write_reg(REG_OUTPUT_LIMIT, '0);
        if ($urandom_range(0, 1) == 1) begin
          send_item({5'($urandom_range(1, 31)), 3'd1}, 1'($urandom_range(0, 1)));
        end else begin
          send_item({5'd3, 3'd0}, 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
      default: begin
        // At stride 1 mode 7 points at the write position itself.
        write_reg(REG_ROW_STRIDE, CfgW'(1));
        send_item({5'($urandom_range(1, 31)), 3'd7}, 1'($urandom_range(0, 1)));
      end
    endcase

    // Requests after the end are swallowed without any result.
    send_item(8'($urandom_range(0, 255)), 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    send_item(8'($urandom_range(0, 255)), 1'b0);

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_stride_lz_decompressor: clean");
    end else begin
      $display("tb_stride_lz_decompressor: errors");
    end
    $finish;
  end

endmodule
